[hw/rtl/qsg_pkg.sv]
// ============================================================================
// qsg_pkg: shared types for the quadrature step generator
// Command and result beats, the back-end state codes and its status group.
// ============================================================================
package qsg_pkg;

   localparam int CHAN_W  = 2;
   localparam int DELTA_W = 16;
   localparam int VIS_W   = 3;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      logic                      is_tick;
      logic                      chan_ok;
      logic [CHAN_W-1:0]         chan;
      logic signed [DELTA_W-1:0] delta;
   } cmd_type;

   typedef struct packed {
      logic [VIS_W-1:0] moved_mask;
      logic [VIS_W-1:0] level_a;
      logic [VIS_W-1:0] level_b;
      logic             last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_TICK = 2'b10
   } back_state_type;

   typedef struct packed {
      logic busy;
      logic any_pending;
      logic push;
      logic push_last;
   } back_status_type;

endpackage

[hw/rtl/qsg_front.sv]
// ============================================================================
// qsg_front: input side of the quadrature step generator
// Accepts request beats, classifies them and holds them in a two-entry queue.
// ============================================================================
module qsg_front
   import qsg_pkg::*;
#(
   parameter int CHANNELS = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_opcode,
   input  logic [CHAN_W-1:0]         req_channel,
   input  logic signed [DELTA_W-1:0] req_delta,
   output logic                      cmd_valid,
   output cmd_type                   cmd,
   input  logic                      cmd_pop
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    new_cmd;
   logic       do_push;
   logic       do_pop;

   always_comb begin
      new_cmd.is_tick = ~req_opcode;
      new_cmd.chan_ok = (32'(req_channel) < CHANNELS);
      new_cmd.chan    = req_channel;
      new_cmd.delta   = req_delta;
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign do_push   = req_push & ~req_full;
   assign do_pop    = cmd_pop & cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

[hw/rtl/qsg_back.sv]
// ============================================================================
// qsg_back: step engine of the quadrature step generator
// Keeps target and position counts, applies adjusts and emits tick steps.
// ============================================================================
module qsg_back
   import qsg_pkg::*;
#(
   parameter int CHANNELS       = 3,
   parameter int STEPS_PER_TICK = 64,
   parameter int COUNT_WIDTH    = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  cmd_type         cmd,
   output logic            cmd_pop,
   output logic            rsp_push,
   output rsp_type         rsp,
   input  logic            rsp_full,
   output back_status_type status
);

   localparam int STEP_W = $clog2(STEPS_PER_TICK + 1);

   logic [COUNT_WIDTH-1:0] target_ff [CHANNELS];
   logic [COUNT_WIDTH-1:0] target_in [CHANNELS];
   logic [COUNT_WIDTH-1:0] pos_ff    [CHANNELS];
   logic [COUNT_WIDTH-1:0] pos_in    [CHANNELS];
   logic [COUNT_WIDTH-1:0] diff      [CHANNELS];
   logic [COUNT_WIDTH-1:0] step_pos  [CHANNELS];
   logic [CHANNELS-1:0]    pend;
   logic [CHANNELS-1:0]    near;
   logic [CHANNELS+VIS_W-1:0] mask_all, a_all, b_all;
   logic [COUNT_WIDTH-1:0] delta_ext;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   back_state_type         state_ff, state_in;
   logic                   step_last;

   assign delta_ext = COUNT_WIDTH'(32'(cmd.delta));

   // Per-channel direction and next position; a channel one count away
   // from its target is done after this step.
   always_comb begin
      mask_all = '0;
      a_all    = '0;
      b_all    = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         diff[c] = target_ff[c] - pos_ff[c];
         pend[c] = |diff[c];
         near[c] = (diff[c] == COUNT_WIDTH'(1)) || (&diff[c]);
         step_pos[c] = diff[c][COUNT_WIDTH-1] ? (pos_ff[c] - COUNT_WIDTH'(1))
                                              : (pos_ff[c] + COUNT_WIDTH'(1));
         if (pend[c]) begin
            mask_all[c] = 1'b1;
            a_all[c]    = step_pos[c][1] ^ step_pos[c][0];
            b_all[c]    = step_pos[c][1];
         end
      end
   end

   assign step_last = ~|(pend & ~near) ||
                      (cnt_ff == STEP_W'(STEPS_PER_TICK - 1));

   always_comb begin
      rsp.moved_mask = mask_all[VIS_W-1:0];
      rsp.level_a    = a_all[VIS_W-1:0];
      rsp.level_b    = b_all[VIS_W-1:0];
      rsp.last       = step_last;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      target_in = target_ff;
      pos_in    = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (!cmd.is_tick) begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     if (cmd.chan_ok && (32'(cmd.chan) == c)) begin
                        target_in[c] = target_ff[c] + delta_ext;
                     end
                  end
               end else if (|pend) begin
                  state_in = ST_TICK;
                  cnt_in   = '0;
               end
            end
         end
         ST_TICK: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               cnt_in   = cnt_ff + STEP_W'(1);
               for (int c = 0; c < CHANNELS; c++) begin
                  if (pend[c]) begin
                     pos_in[c] = step_pos[c];
                  end
               end
               if (step_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            target_ff[c] <= '0;
            pos_ff[c]    <= '0;
         end
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         target_ff <= target_in;
         pos_ff    <= pos_in;
      end
   end

   always_comb begin
      status.busy        = (state_ff == ST_TICK);
      status.any_pending = |pend;
      status.push        = rsp_push;
      status.push_last   = step_last;
   end

endmodule

[hw/rtl/qsg_rsp_queue.sv]
// ============================================================================
// qsg_rsp_queue: result queue of the quadrature step generator
// Two-entry queue that parts the step engine from the result receiver.
// ============================================================================
module qsg_rsp_queue
   import qsg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output rsp_type pop_data
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/quadrature_step_generator.sv]
// ============================================================================
// quadrature_step_generator: three-channel quadrature encoder emulator
// Request beats adjust channel targets or request a tick; result beats
// carry one step of A/B levels each.
// ============================================================================
// Usage:
//   Request channel (req_push / req_full): opcode 1 adds a signed delta to
//   one channel's target and gives no result; opcode 0 is a tick, which
//   emits one result beat per step until every position meets its target
//   or STEPS_PER_TICK beats have gone out. The final beat of a tick has
//   rsp_last set; a tick with nothing pending gives no beat.
//   Result channel (rsp_empty / rsp_pop): the oldest result is on the rsp_
//   ports while rsp_empty is low.
//   A two-entry command queue feeds the step engine. An adjust is applied
//   in the idle state; a tick moves the engine to its tick state, which
//   emits one step per cycle while the result queue is not full and takes
//   no new command until the tick ends.
//   If the receiver stalls, the two-entry result queue fills and the engine
//   holds its step; requests keep queuing until the command queue is full.
//   Reset clears all targets and positions to zero and empties both queues.
// ============================================================================
module quadrature_step_generator
   import qsg_pkg::*;
#(
   parameter int CHANNELS       = 3,
   parameter int STEPS_PER_TICK = 64,
   parameter int COUNT_WIDTH    = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_opcode,
   input  logic [CHAN_W-1:0]         req_channel,
   input  logic signed [DELTA_W-1:0] req_delta,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [VIS_W-1:0]          rsp_moved_mask,
   output logic [VIS_W-1:0]          rsp_level_a,
   output logic [VIS_W-1:0]          rsp_level_b,
   output logic                      rsp_last
);

   cmd_type         cmd;
   logic            cmd_valid;
   logic            cmd_pop;
   rsp_type         step_rsp;
   logic            step_push;
   logic            step_full;
   rsp_type         head_rsp;
   back_status_type back_status;

   qsg_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_opcode  (req_opcode),
      .req_channel (req_channel),
      .req_delta   (req_delta),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   qsg_back #(
      .CHANNELS       (CHANNELS),
      .STEPS_PER_TICK (STEPS_PER_TICK),
      .COUNT_WIDTH    (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (step_push),
      .rsp       (step_rsp),
      .rsp_full  (step_full),
      .status    (back_status)
   );

   qsg_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_push),
      .push_data (step_rsp),
      .full      (step_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (head_rsp)
   );

   assign rsp_moved_mask = head_rsp.moved_mask;
   assign rsp_level_a    = head_rsp.level_a;
   assign rsp_level_b    = head_rsp.level_b;
   assign rsp_last       = head_rsp.last;

   // The engine never pushes a step beat into a full result queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      step_push |-> !step_full)
      else $error("step beat pushed into full result queue");

   // While a tick is running some channel is still away from its target.
   a_busy_has_pending: assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> back_status.any_pending)
      else $error("tick running with nothing pending");

   // A step beat that is not the last one keeps the tick running.
   a_not_last_stays_busy: assert property (@(posedge clock) disable iff (reset)
      (back_status.push && !back_status.push_last) |=> back_status.busy)
      else $error("tick ended without a last beat");

   // A last beat ends the tick.
   a_last_ends_tick: assert property (@(posedge clock) disable iff (reset)
      (back_status.push && back_status.push_last) |=> !back_status.busy)
      else $error("tick kept running after its last beat");

endmodule

[sim/quadrature_step_generator_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// quadrature_step_generator_tb: regression bench for the step generator
// Drives adjust and tick beats into the request queue and predicts every step
// beat of the three emulated encoders. Directed cases cover idle ticks, an
// out-of-range channel, Gray phases in both directions, wrap through zero and
// the per-tick step limit. A long receiver hold fills the block, and random
// traffic follows. Both sides idle at random between beats, except in the hold test and early random traffic.
// ============================================================================
module quadrature_step_generator_tb;
   import qsg_pkg::*;

   localparam int NUM_CH       = 3;
   localparam int STEP_LIMIT   = 64;
   localparam int COUNT_W      = 32;
   localparam int IDLE_PCT     = 37;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 85;
   localparam int SHOWN_ERRORS = 10;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_ADJUST = 1'b1;

   localparam logic [CHAN_W-1:0] CH_NONE = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      req_push;
   logic                      req_full;
   logic                      req_opcode;
   logic [CHAN_W-1:0]         req_channel;
   logic signed [DELTA_W-1:0] req_delta;
   logic                      rsp_empty;
   logic                      rsp_pop;
   logic [VIS_W-1:0]          rsp_moved_mask;
   logic [VIS_W-1:0]          rsp_level_a;
   logic [VIS_W-1:0]          rsp_level_b;
   logic                      rsp_last;

   logic [COUNT_W-1:0] target_cnt [NUM_CH];
   logic [COUNT_W-1:0] position_cnt [NUM_CH];
   rsp_type            expected_steps [$];

   bit idle_on;
   bit hold_pending;
   int mismatches;
   int quiet_cycles;
   int hold_count;

   quadrature_step_generator #(
      .CHANNELS       (NUM_CH),
      .STEPS_PER_TICK (STEP_LIMIT),
      .COUNT_WIDTH    (COUNT_W)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_channel    (req_channel),
      .req_delta      (req_delta),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_moved_mask (rsp_moved_mask),
      .rsp_level_a    (rsp_level_a),
      .rsp_level_b    (rsp_level_b),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Each step moves every lagging channel one count the short way round;
   // A/B follow the Gray phase of the new position.
   function automatic void emit_tick_steps();
      rsp_type            step;
      logic [COUNT_W-1:0] lag;
      int                 n;
      n = 0;
      while (n < STEP_LIMIT) begin
         step = '0;
         for (int c = 0; c < NUM_CH; c++) begin
            lag = target_cnt[c] - position_cnt[c];
            if (lag != '0) begin
               if (lag[COUNT_W-1])
                  position_cnt[c] = position_cnt[c] - 1'b1;
               else
                  position_cnt[c] = position_cnt[c] + 1'b1;
               step.moved_mask[c] = 1'b1;
               step.level_a[c]    = position_cnt[c][1] ^ position_cnt[c][0];
               step.level_b[c]    = position_cnt[c][1];
            end
         end
         if (step.moved_mask == '0)
            break;
         expected_steps.push_back(step);
         n++;
      end
      if (n > 0)
         expected_steps[expected_steps.size() - 1].last = 1'b1;
   endfunction

   function automatic void predict_request(input logic op, input logic [CHAN_W-1:0] ch,
                                           input logic signed [DELTA_W-1:0] d);
      if (op == OP_ADJUST) begin
         if (ch < NUM_CH)
            target_cnt[ch] = target_cnt[ch] + {{(COUNT_W - DELTA_W){d[DELTA_W-1]}}, d};
      end else begin
         emit_tick_steps();
      end
   endfunction

   // Returns in the step of the accepting edge with push still high, so a
   // following beat can be offered back to back.
   task automatic send_request(input logic op, input logic [CHAN_W-1:0] ch,
                               input logic signed [DELTA_W-1:0] d);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_opcode  <= op;
      req_channel <= ch;
      req_delta   <= d;
      do begin
         @(posedge clock);
      end while (req_full);
      predict_request(op, ch, d);
   endtask

   task automatic send_tick();
      send_request(OP_TICK, CHAN_W'($urandom_range(0, 3)), DELTA_W'($urandom()));
   endtask

   // Receiver: random stalls, plus one long hold when a test asks for it.
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_pop <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
         end
         rsp_pop <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{moved_mask: rsp_moved_mask, level_a: rsp_level_a,
                 level_b: rsp_level_b, last: rsp_last};
         if (expected_steps.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
               $display("unexpected step beat: mask=%b a=%b b=%b last=%b",
                        got.moved_mask, got.level_a, got.level_b, got.last);
         end else begin
            want = expected_steps.pop_front();
            if (got.moved_mask != want.moved_mask || got.level_a != want.level_a ||
                got.level_b != want.level_b || got.last != want.last) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS)
                  $display("step mismatch: expected mask=%b a=%b b=%b last=%b, got mask=%b a=%b b=%b last=%b",
                           want.moved_mask, want.level_a, want.level_b, want.last,
                           got.moved_mask, got.level_a, got.level_b, got.last);
            end
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("quadrature_step_generator regression: fail");
         $finish;
      end
   end

   task automatic test_idle_and_bad_channel();
      send_tick();
      send_request(OP_ADJUST, CH_NONE, 16'sh7FFF);
      send_tick();
   endtask

   task automatic test_phase_and_direction();
      send_request(OP_ADJUST, 2'd0, 16'sd1);
      send_tick();
      // Channel 1 steps down through zero while channel 2 steps up.
      send_request(OP_ADJUST, 2'd1, -16'sd1);
      send_request(OP_ADJUST, 2'd2, 16'sd2);
      send_tick();
      send_request(OP_ADJUST, 2'd2, -16'sd3);
      send_tick();
   endtask

   task automatic test_step_limit_and_wrap();
      send_request(OP_ADJUST, 2'd0, 16'sh7FFF);
      send_tick();
      send_request(OP_ADJUST, 2'd0, 16'sh8000);
      send_tick();
      send_tick();
   endtask

   task automatic test_all_channels();
      send_request(OP_ADJUST, 2'd0, 16'sd100);
      send_request(OP_ADJUST, 2'd1, 16'sd100);
      send_request(OP_ADJUST, 2'd2, -16'sd100);
      send_tick();
      send_tick();
      send_tick();
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      send_request(OP_ADJUST, 2'd0, 16'sd300);
      send_request(OP_ADJUST, 2'd1, -16'sd200);
      send_request(OP_ADJUST, 2'd2, 16'sd150);
      hold_pending = 1'b1;
      for (int i = 0; i < 6; i++) begin
         send_tick();
         send_request(OP_ADJUST, CHAN_W'($urandom_range(0, 2)), DELTA_W'($urandom_range(0, 40)));
      end
   endtask

   task automatic test_random_traffic();
      logic [CHAN_W-1:0]         ch;
      logic signed [DELTA_W-1:0] d;
      int                        pick;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // The first third runs with no idling on either side.
         idle_on = (i >= RANDOM_ITEMS / 3);
         if ($urandom_range(0, 99) < 55) begin
            ch   = CHAN_W'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 85)
               d = DELTA_W'($urandom_range(0, 192) - 96);
            else if (pick < 95)
               d = DELTA_W'($urandom_range(0, 2047) - 1024);
            else
               d = DELTA_W'($urandom());
            send_request(OP_ADJUST, ch, d);
         end else begin
            send_tick();
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_push     = 1'b0;
      req_opcode   = OP_TICK;
      req_channel  = '0;
      req_delta    = '0;
      idle_on      = 1'b1;
      hold_pending = 1'b0;
      mismatches   = 0;
      quiet_cycles = 0;
      for (int c = 0; c < NUM_CH; c++) begin
         target_cnt[c]   = '0;
         position_cnt[c] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_bad_channel();
      test_phase_and_direction();
      test_step_limit_and_wrap();
      test_all_channels();
      test_backpressure();
      test_random_traffic();
      req_push <= 1'b0;

      while (expected_steps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("quadrature_step_generator regression: pass");
      else
         $display("quadrature_step_generator regression: fail");
      $finish;
   end

endmodule
